@@ hw/rtl/cmg_pkg.sv @@
// Shared types, register codes and fixed-point constants of the cylinder mesh generator.
`default_nettype none

package cmg_pkg;

  // Long-division datapath: divisor is a slice or span count, numerator a scaled coordinate
  localparam int DivisorW = 11;
  localparam int NumW     = 44;

  // Angle and trig constants, Q30
  localparam logic [31:0] PiQ30  = 32'd3373259426;
  localparam logic [30:0] OneQ30 = 31'h4000_0000;

  localparam int HornerSteps = 6;

  // Configuration register indexes
  localparam logic [2:0] CFG_SLICES = 3'd0;
  localparam logic [2:0] CFG_RINGS  = 3'd1;
  localparam logic [2:0] CFG_RADIUS = 3'd2;
  localparam logic [2:0] CFG_YOFF   = 3'd3;
  localparam logic [2:0] CFG_HEIGHT = 3'd4;

  // Reciprocals for the Horner divisors: floor(v/d) == (v*M) >> s for any v below 2^32
  typedef logic [33:0] recip_t;
  typedef logic [5:0]  rshift_t;

  localparam recip_t SIN_RECIP [HornerSteps] = '{
    34'(((64'd1 << 40) + 64'd155) / 64'd156),
    34'(((64'd1 << 39) + 64'd109) / 64'd110),
    34'(((64'd1 << 39) + 64'd71) / 64'd72),
    34'(((64'd1 << 38) + 64'd41) / 64'd42),
    34'(((64'd1 << 37) + 64'd19) / 64'd20),
    34'(((64'd1 << 35) + 64'd5) / 64'd6)
  };
  localparam rshift_t SIN_SHIFT [HornerSteps] = '{
    6'd40, 6'd39, 6'd39, 6'd38, 6'd37, 6'd35
  };

  localparam recip_t COS_RECIP [HornerSteps] = '{
    34'(((64'd1 << 40) + 64'd181) / 64'd182),
    34'(((64'd1 << 40) + 64'd131) / 64'd132),
    34'(((64'd1 << 39) + 64'd89) / 64'd90),
    34'(((64'd1 << 38) + 64'd55) / 64'd56),
    34'(((64'd1 << 37) + 64'd29) / 64'd30),
    34'(((64'd1 << 36) + 64'd11) / 64'd12)
  };
  localparam rshift_t COS_SHIFT [HornerSteps] = '{
    6'd40, 6'd40, 6'd39, 6'd38, 6'd37, 6'd36
  };

  // Per-request bookkeeping that rides alongside the dividers
  typedef struct packed {
    logic        func;
    logic        bad;
    logic [9:0]  ring;
    logic [10:0] col;
    logic [21:0] idx_a;
    logic [21:0] idx_c;
  } meta_t;

  // Per-request state through the trig section
  typedef struct packed {
    meta_t              meta;
    logic [1:0]         quad;
    logic [30:0]        ang;
    logic [31:0]        x2;
    logic [14:0]        tex_u;
    logic [14:0]        tex_v;
    logic signed [18:0] py;
  } post_t;

endpackage

`default_nettype wire

@@ hw/rtl/cmg_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, divisor held static.
`default_nettype none

module cmg_div (
  input  wire logic                           clk,
  input  wire logic [cmg_pkg::DivisorW-1:0]   divisor,
  input  wire logic [cmg_pkg::NumW-1:0]       num,
  output logic      [cmg_pkg::NumW-1:0]       quo
);

  localparam int DW = cmg_pkg::DivisorW;
  localparam int NW = cmg_pkg::NumW;

  logic [DW-1:0] rem_r [NW];
  logic [NW-1:0] nq_r  [NW];
  logic [DW:0]   trial [NW];
  logic          ge    [NW];

  // Trial subtract for every stage
  always_comb begin
    for (int i = 0; i < NW; i++) begin
      if (i == 0) begin
        trial[i] = {{DW{1'b0}}, num[NW-1]};
      end else begin
        trial[i] = {rem_r[i-1], nq_r[i-1][NW-1]};
      end
      ge[i] = (trial[i] >= {1'b0, divisor});
    end
  end

  // Remainder and shifting numerator/quotient word per stage
  always_ff @(posedge clk) begin
    for (int i = 0; i < NW; i++) begin
      rem_r[i] <= ge[i] ? DW'(trial[i] - {1'b0, divisor}) : DW'(trial[i]);
      if (i == 0) begin
        nq_r[i] <= {num[NW-2:0], ge[i]};
      end else begin
        nq_r[i] <= {nq_r[i-1][NW-2:0], ge[i]};
      end
    end
  end

  assign quo = nq_r[NW-1];

endmodule

`default_nettype wire

@@ hw/rtl/cylinder_mesh_generator.sv @@
// Open cylinder tessellator: vertex positions, texture coordinates and quad indices.
//
// One request (vertex or quad) is taken every clock cycle while busy is low; busy is
// high while reset is applied and for the first cycle after it is released. Every
// request returns exactly one result beat, marked by out_strobe, after it passes the
// entry register, the bit-per-stage long dividers that produce the column angle,
// texture coordinates and ring height, the angle, Horner sine/cosine and radius
// scaling stages and the output register. The result cannot be held off.
// Configuration writes are always ready and must only be issued while no request
// is in flight.
`default_nettype none

module cylinder_mesh_generator #(
  parameter int COORD_WIDTH = 16,
  parameter int INDEX_WIDTH = 16,
  parameter int MAX_SLICES  = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_func,
  input  wire logic [9:0]                    in_ring,
  input  wire logic [10:0]                   in_column,
  output logic                               out_strobe,
  output logic signed [COORD_WIDTH-1:0]      out_pos_x,
  output logic signed [COORD_WIDTH-1:0]      out_pos_y,
  output logic signed [COORD_WIDTH-1:0]      out_pos_z,
  output logic        [14:0]                 out_tex_u,
  output logic        [14:0]                 out_tex_v,
  output logic        [INDEX_WIDTH-1:0]      out_corner_a,
  output logic        [INDEX_WIDTH-1:0]      out_corner_b,
  output logic        [INDEX_WIDTH-1:0]      out_corner_c,
  output logic        [INDEX_WIDTH-1:0]      out_corner_d,
  output logic        [INDEX_WIDTH-1:0]      out_corner_e,
  output logic        [INDEX_WIDTH-1:0]      out_corner_f,
  output logic                               out_bad_request,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [2:0]                    cfg_index,
  input  wire logic [15:0]                   cfg_data
);

  localparam int DivLat  = cmg_pkg::NumW;
  localparam int NW      = cmg_pkg::NumW;
  localparam int PostLat = 17;
  localparam int Latency = DivLat + PostLat + 2;

  localparam logic signed [33:0] CoordHi = (34'sd1 <<< (COORD_WIDTH - 1)) - 34'sd1;
  localparam logic signed [33:0] CoordLo = -CoordHi - 34'sd1;

  function automatic logic [COORD_WIDTH-1:0] sat_coord(input logic signed [19:0] v);
    logic signed [33:0] w;
    w = 34'(v);
    if (w > CoordHi) begin
      w = CoordHi;
    end else if (w < CoordLo) begin
      w = CoordLo;
    end
    return COORD_WIDTH'(w);
  endfunction

  // ---------------------------------------------------------------- config
  logic [10:0]        slices_r, rings_r;
  logic [15:0]        radius_r, height_r;
  logic signed [15:0] yoff_r;
  logic               busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slices_r <= 11'd16;
      rings_r  <= 11'd2;
      radius_r <= 16'd256;
      yoff_r   <= 16'sd0;
      height_r <= 16'd256;
      busy_r   <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          cmg_pkg::CFG_SLICES: slices_r <= cfg_data[10:0];
          cmg_pkg::CFG_RINGS:  rings_r  <= cfg_data[10:0];
          cmg_pkg::CFG_RADIUS: radius_r <= cfg_data;
          cmg_pkg::CFG_YOFF:   yoff_r   <= $signed(cfg_data);
          cmg_pkg::CFG_HEIGHT: height_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign cfg_ready = 1'b1;
  assign busy      = busy_r;

  logic        accept;
  logic [10:0] span;
  logic        cfg_bad;

  assign accept  = start && !busy_r;
  assign span    = rings_r - 11'd1;
  assign cfg_bad = (slices_r == 11'd0) || (int'(slices_r) > MAX_SLICES) ||
                   (rings_r < 11'd2) || (rings_r > 11'd1024);

  // ---------------------------------------------------------------- entry stage
  logic        e1_vld_r;
  logic        e1_func_r;
  logic [9:0]  e1_ring_r;
  logic [10:0] e1_col_r;
  logic [21:0] e1_m_r;
  logic [11:0] sl_p1;

  assign sl_p1 = {1'b0, slices_r} + 12'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_vld_r <= 1'b0;
    end else begin
      e1_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    e1_func_r <= in_func;
    e1_ring_r <= in_ring;
    e1_col_r  <= in_column;
    e1_m_r    <= 22'(in_ring) * 22'(sl_p1);
  end

  // Dividend words for the four rounded quotients
  logic [NW-1:0] num_phase, num_texu, num_ry, num_texv;
  logic [25:0]   hr_prod;

  assign hr_prod   = 26'(height_r) * 26'(e1_ring_r);
  assign num_phase = NW'({e1_col_r, 32'd0}) + NW'(slices_r[10:1]);
  assign num_texu  = NW'({e1_col_r, 14'd0}) + NW'(slices_r[10:1]);
  assign num_ry    = NW'(hr_prod) + NW'(span[10:1]);
  assign num_texv  = NW'({e1_ring_r, 14'd0}) + NW'(span[10:1]);

  logic [NW-1:0] q_phase, q_texu, q_ry, q_texv;

  cmg_div u_div_phase (.clk(clk), .divisor(slices_r), .num(num_phase), .quo(q_phase));
  cmg_div u_div_texu  (.clk(clk), .divisor(slices_r), .num(num_texu),  .quo(q_texu));
  cmg_div u_div_ry    (.clk(clk), .divisor(span),     .num(num_ry),    .quo(q_ry));
  cmg_div u_div_texv  (.clk(clk), .divisor(span),     .num(num_texv),  .quo(q_texv));

  // Indices and range checks, then delay to meet the divider outputs
  cmg_pkg::meta_t meta_in;
  logic [21:0]    idx_max;
  logic           ovf;

  always_comb begin
    meta_in.func  = e1_func_r;
    meta_in.ring  = e1_ring_r;
    meta_in.col   = e1_col_r;
    meta_in.idx_a = e1_m_r + 22'(e1_col_r);
    meta_in.idx_c = meta_in.idx_a + 22'(sl_p1);
    idx_max       = meta_in.idx_c + 22'd1;
    ovf           = |(idx_max >> INDEX_WIDTH);
    if (e1_func_r) begin
      meta_in.bad = cfg_bad || ({1'b0, e1_ring_r} >= span) || (e1_col_r >= slices_r) || ovf;
    end else begin
      meta_in.bad = cfg_bad || ({1'b0, e1_ring_r} >= rings_r) || (e1_col_r > slices_r);
    end
  end

  cmg_pkg::meta_t md_r     [DivLat];
  logic           md_vld_r [DivLat];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DivLat; i++) md_vld_r[i] <= 1'b0;
    end else begin
      md_vld_r[0] <= e1_vld_r;
      for (int i = 1; i < DivLat; i++) md_vld_r[i] <= md_vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    md_r[0] <= meta_in;
    for (int i = 1; i < DivLat; i++) md_r[i] <= md_r[i-1];
  end

  // ---------------------------------------------------------------- trig section
  cmg_pkg::post_t post_in, post_sq;
  logic [61:0]    ang_prod, sq_prod;

  assign ang_prod = 62'(q_phase[29:0]) * 62'(cmg_pkg::PiQ30);

  always_comb begin
    post_in.meta  = md_r[DivLat-1];
    post_in.quad  = q_phase[31:30];
    post_in.ang   = ang_prod[61:31];
    post_in.x2    = '0;
    post_in.tex_u = q_texu[14:0];
    post_in.tex_v = q_texv[14:0];
    post_in.py    = $signed({2'b00, q_ry[16:0]}) + 19'(yoff_r);
  end

  cmg_pkg::post_t pd_r     [PostLat];
  logic           pd_vld_r [PostLat];

  assign sq_prod = 62'(pd_r[0].ang) * 62'(pd_r[0].ang);

  always_comb begin
    post_sq    = pd_r[0];
    post_sq.x2 = sq_prod[61:30];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PostLat; i++) pd_vld_r[i] <= 1'b0;
    end else begin
      pd_vld_r[0] <= md_vld_r[DivLat-1];
      for (int i = 1; i < PostLat; i++) pd_vld_r[i] <= pd_vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    pd_r[0] <= post_in;
    pd_r[1] <= post_sq;
    for (int i = 2; i < PostLat; i++) pd_r[i] <= pd_r[i-1];
  end

  // Horner chains: even steps multiply by x^2, odd steps divide and subtract from one
  localparam int HSteps = 2 * cmg_pkg::HornerSteps;

  logic [31:0] hs_r [HSteps];
  logic [31:0] hc_r [HSteps];
  logic [31:0] hs_nxt [HSteps];
  logic [31:0] hc_nxt [HSteps];

  always_comb begin
    logic [63:0] ms, mc;
    logic [65:0] rs, rc;
    logic [31:0] ts, tc;
    for (int j = 0; j < HSteps; j++) begin
      if ((j % 2) == 0) begin
        if (j == 0) begin
          ts = {1'b0, cmg_pkg::OneQ30};
          tc = {1'b0, cmg_pkg::OneQ30};
        end else begin
          ts = hs_r[j-1];
          tc = hc_r[j-1];
        end
        ms        = 64'(pd_r[1+j].x2) * 64'(ts);
        mc        = 64'(pd_r[1+j].x2) * 64'(tc);
        hs_nxt[j] = ms[61:30];
        hc_nxt[j] = mc[61:30];
      end else begin
        rs        = 66'(hs_r[j-1]) * 66'(cmg_pkg::SIN_RECIP[j/2]);
        rc        = 66'(hc_r[j-1]) * 66'(cmg_pkg::COS_RECIP[j/2]);
        hs_nxt[j] = {1'b0, cmg_pkg::OneQ30} - 32'(rs >> cmg_pkg::SIN_SHIFT[j/2]);
        hc_nxt[j] = {1'b0, cmg_pkg::OneQ30} - 32'(rc >> cmg_pkg::COS_SHIFT[j/2]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < HSteps; j++) begin
      hs_r[j] <= hs_nxt[j];
      hc_r[j] <= hc_nxt[j];
    end
  end

  // Final sine product and halved cosine term
  logic [62:0] sn_prod;
  logic [63:0] pc_prod;
  logic [31:0] sn_r;
  logic [32:0] pc_r;

  assign sn_prod = 63'(pd_r[13].ang) * 63'(hs_r[HSteps-1]);
  assign pc_prod = 64'(pd_r[13].x2) * 64'(hc_r[HSteps-1]);

  always_ff @(posedge clk) begin
    sn_r <= sn_prod[61:30];
    pc_r <= pc_prod[63:31];
  end

  // Cosine clamp and quadrant mapping
  logic [31:0] cs;
  logic [31:0] mx_r, mz_r;
  logic        negx_r, negz_r;

  assign cs = (pc_r >= 33'(cmg_pkg::OneQ30)) ? 32'd0
                                              : 32'(33'(cmg_pkg::OneQ30) - pc_r);

  always_ff @(posedge clk) begin
    unique case (pd_r[14].quad)
      2'd0: begin mx_r <= cs;   mz_r <= sn_r; negx_r <= 1'b0; negz_r <= 1'b0; end
      2'd1: begin mx_r <= sn_r; mz_r <= cs;   negx_r <= 1'b1; negz_r <= 1'b0; end
      2'd2: begin mx_r <= cs;   mz_r <= sn_r; negx_r <= 1'b1; negz_r <= 1'b1; end
      default: begin mx_r <= sn_r; mz_r <= cs; negx_r <= 1'b0; negz_r <= 1'b1; end
    endcase
  end

  // Radius scaling with rounding half up
  logic [47:0] px_prod, pz_prod;
  logic [17:0] magx_r, magz_r;
  logic        negx2_r, negz2_r;

  assign px_prod = 48'(radius_r) * 48'(mx_r) + 48'h2000_0000;
  assign pz_prod = 48'(radius_r) * 48'(mz_r) + 48'h2000_0000;

  always_ff @(posedge clk) begin
    magx_r  <= px_prod[47:30];
    magz_r  <= pz_prod[47:30];
    negx2_r <= negx_r;
    negz2_r <= negz_r;
  end

  // ---------------------------------------------------------------- result beat
  logic signed [19:0] sx, sz;

  assign sx = negx2_r ? -$signed({2'b00, magx_r}) : $signed({2'b00, magx_r});
  assign sz = negz2_r ? -$signed({2'b00, magz_r}) : $signed({2'b00, magz_r});

  logic                   out_strobe_r;
  logic [COORD_WIDTH-1:0] pos_x_r, pos_y_r, pos_z_r;
  logic [14:0]            tex_u_r, tex_v_r;
  logic [INDEX_WIDTH-1:0] ca_r, cb_r, cc_r, cf_r;
  logic                   bad_r;
  cmg_pkg::post_t         fin;
  logic [21:0]            a_p1, c_p1;

  assign fin  = pd_r[PostLat-1];
  assign a_p1 = fin.meta.idx_a + 22'd1;
  assign c_p1 = fin.meta.idx_c + 22'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= pd_vld_r[PostLat-1];
    end
  end

  always_ff @(posedge clk) begin
    pos_x_r <= '0;
    pos_y_r <= '0;
    pos_z_r <= '0;
    tex_u_r <= '0;
    tex_v_r <= '0;
    ca_r    <= '0;
    cb_r    <= '0;
    cc_r    <= '0;
    cf_r    <= '0;
    bad_r   <= fin.meta.bad;
    priority if (fin.meta.bad) begin
    end else if (!fin.meta.func) begin
      pos_x_r <= sat_coord(sx);
      pos_y_r <= sat_coord(20'(fin.py));
      pos_z_r <= sat_coord(sz);
      tex_u_r <= fin.tex_u;
      tex_v_r <= fin.tex_v;
    end else begin
      ca_r <= INDEX_WIDTH'(fin.meta.idx_a);
      cb_r <= INDEX_WIDTH'(a_p1);
      cc_r <= INDEX_WIDTH'(fin.meta.idx_c);
      cf_r <= INDEX_WIDTH'(c_p1);
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_pos_x       = $signed(pos_x_r);
  assign out_pos_y       = $signed(pos_y_r);
  assign out_pos_z       = $signed(pos_z_r);
  assign out_tex_u       = tex_u_r;
  assign out_tex_v       = tex_v_r;
  assign out_corner_a    = ca_r;
  assign out_corner_b    = cb_r;
  assign out_corner_c    = cc_r;
  assign out_corner_d    = cc_r;
  assign out_corner_e    = cb_r;
  assign out_corner_f    = cf_r;
  assign out_bad_request = bad_r;

  // ---------------------------------------------------------------- checks
  a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##Latency out_strobe)
    else $error("request beat did not produce a result at the fixed latency");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, Latency))
    else $error("result beat without a matching request");

  a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_bad_request) |->
      (out_corner_a == '0 && out_corner_f == '0 && out_pos_x == '0 &&
       out_pos_y == '0 && out_tex_u == '0))
    else $error("rejected request carries non-zero fields");

endmodule

`default_nettype wire

@@ tb/cylinder_mesh_generator_tb.sv @@
// Self-checking testbench of the cylinder mesh generator: directed table, random phases.
`timescale 1ns / 100ps

module cylinder_mesh_generator_tb;

  typedef struct {
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] pos_z;
    logic [14:0] tex_u;
    logic [14:0] tex_v;
    logic [15:0] ca, cb, cc, cd, ce, cf;
    logic        bad;
  } mesh_out_t;

  typedef struct {
    logic        func;
    logic [9:0]  ring;
    logic [10:0] col;
    logic        known;
    mesh_out_t   res;
  } req_row_t;

  logic clk, rst_n, start, busy;
  logic in_func;
  logic [9:0] in_ring;
  logic [10:0] in_column;
  logic out_strobe;
  logic signed [15:0] out_pos_x, out_pos_y, out_pos_z;
  logic [14:0] out_tex_u, out_tex_v;
  logic [15:0] out_corner_a, out_corner_b, out_corner_c;
  logic [15:0] out_corner_d, out_corner_e, out_corner_f;
  logic out_bad_request;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;

  cylinder_mesh_generator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_ring(in_ring), .in_column(in_column),
    .out_strobe(out_strobe), .out_pos_x(out_pos_x), .out_pos_y(out_pos_y),
    .out_pos_z(out_pos_z), .out_tex_u(out_tex_u), .out_tex_v(out_tex_v),
    .out_corner_a(out_corner_a), .out_corner_b(out_corner_b),
    .out_corner_c(out_corner_c), .out_corner_d(out_corner_d),
    .out_corner_e(out_corner_e), .out_corner_f(out_corner_f),
    .out_bad_request(out_bad_request), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the configuration registers
  longint unsigned m_slices, m_rings, m_radius, m_yoff, m_height;

  mesh_out_t pending_results[$];
  req_row_t  dir_rows[$];
  int        n_fail;
  int        cycles;
  bit        no_idle;

  localparam longint unsigned ONE = 64'd1 << 30;
  localparam longint unsigned PI_Q = 64'd3373259426;
  localparam int TIMEOUT = 400000;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > TIMEOUT) begin
      $display("cylinder_mesh_generator_tb failed");
      $finish;
    end
  end

  // Horner evaluation of the truncated Taylor series
  function automatic longint unsigned poly_q30(longint unsigned x2, bit is_cos);
    longint unsigned t, d;
    t = ONE;
    for (int k = 0; k < 6; k++) begin
      if (is_cos)
        case (k) 0: d = 182; 1: d = 132; 2: d = 90; 3: d = 56; 4: d = 30; default: d = 12; endcase
      else
        case (k) 0: d = 156; 1: d = 110; 2: d = 72; 3: d = 42; 4: d = 20; default: d = 6; endcase
      t = ONE - ((x2 * t) >> 30) / d;
    end
    return t;
  endfunction

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic longint scale_by_radius(longint unsigned mag, bit neg);
    longint m;
    m = longint'((m_radius * mag + (ONE >> 1)) >> 30);
    return neg ? -m : m;
  endfunction

  // Expected result of one request under the current register values
  function automatic mesh_out_t tessellate(logic f, logic [9:0] r, logic [10:0] c);
    mesh_out_t o;
    longint unsigned ring, col, phase, ang, cs, sn, x2, span, a, cidx, p;
    longint ry, off, px, pz;
    bit bad;
    o = '{default: '0};
    ring = r;
    col = c;
    bad = (m_slices == 0 || m_slices > 1024 || m_rings < 2 || m_rings > 1024);
    if (!bad) begin
      if (f == 1'b0) bad = (ring >= m_rings || col > m_slices);
      else bad = (ring >= m_rings - 1 || col >= m_slices ||
                  (ring + 1) * (m_slices + 1) + col + 1 > 65535);
    end
    if (bad) begin
      o.bad = 1'b1;
      return o;
    end
    if (f == 1'b0) begin
      phase = (((col << 32) + m_slices / 2) / m_slices) & 64'hFFFF_FFFF;
      ang = ((phase & (ONE - 1)) * PI_Q) >> 31;
      x2 = (ang * ang) >> 30;
      sn = (ang * poly_q30(x2, 1'b0)) >> 30;
      p = ((x2 * poly_q30(x2, 1'b1)) >> 30) / 2;
      cs = (p >= ONE) ? 0 : ONE - p;
      case (phase[31:30])
        2'd0: begin px = scale_by_radius(cs, 0); pz = scale_by_radius(sn, 0); end
        2'd1: begin px = scale_by_radius(sn, 1); pz = scale_by_radius(cs, 0); end
        2'd2: begin px = scale_by_radius(cs, 1); pz = scale_by_radius(sn, 1); end
        default: begin px = scale_by_radius(sn, 0); pz = scale_by_radius(cs, 1); end
      endcase
      span = m_rings - 1;
      off = longint'(m_yoff & 16'h7FFF) - longint'(m_yoff & 16'h8000);
      ry = longint'((m_height * ring + span / 2) / span);
      o.pos_x = clamp16(px);
      o.pos_y = clamp16(ry + off);
      o.pos_z = clamp16(pz);
      o.tex_u = 15'((col * 16384 + m_slices / 2) / m_slices);
      o.tex_v = 15'((ring * 16384 + span / 2) / span);
    end else begin
      a = ring * (m_slices + 1) + col;
      cidx = a + m_slices + 1;
      o.ca = a[15:0];
      o.cb = 16'(a + 1);
      o.cc = cidx[15:0];
      o.cd = cidx[15:0];
      o.ce = 16'(a + 1);
      o.cf = 16'(cidx + 1);
    end
    return o;
  endfunction

  // Result checker: every strobed beat against the oldest expectation
  always @(posedge clk) begin
    mesh_out_t e;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat");
        n_fail++;
      end else begin
        e = pending_results.pop_front();
        if (out_pos_x !== e.pos_x) begin
          $error("pos_x exp %h got %h", e.pos_x, out_pos_x); n_fail++; end
        if (out_pos_y !== e.pos_y) begin
          $error("pos_y exp %h got %h", e.pos_y, out_pos_y); n_fail++; end
        if (out_pos_z !== e.pos_z) begin
          $error("pos_z exp %h got %h", e.pos_z, out_pos_z); n_fail++; end
        if (out_tex_u !== e.tex_u) begin
          $error("tex_u exp %h got %h", e.tex_u, out_tex_u); n_fail++; end
        if (out_tex_v !== e.tex_v) begin
          $error("tex_v exp %h got %h", e.tex_v, out_tex_v); n_fail++; end
        if (out_corner_a !== e.ca) begin
          $error("corner_a exp %h got %h", e.ca, out_corner_a); n_fail++; end
        if (out_corner_b !== e.cb) begin
          $error("corner_b exp %h got %h", e.cb, out_corner_b); n_fail++; end
        if (out_corner_c !== e.cc) begin
          $error("corner_c exp %h got %h", e.cc, out_corner_c); n_fail++; end
        if (out_corner_d !== e.cd) begin
          $error("corner_d exp %h got %h", e.cd, out_corner_d); n_fail++; end
        if (out_corner_e !== e.ce) begin
          $error("corner_e exp %h got %h", e.ce, out_corner_e); n_fail++; end
        if (out_corner_f !== e.cf) begin
          $error("corner_f exp %h got %h", e.cf, out_corner_f); n_fail++; end
        if (out_bad_request !== e.bad) begin
          $error("bad_request exp %b got %b", e.bad, out_bad_request); n_fail++; end
      end
    end
  end

  // One request beat; expectation is typed in or predicted
  task automatic send_req(logic f, logic [9:0] r, logic [10:0] c, bit known, mesh_out_t kres);
    int gap;
    gap = no_idle ? 0 : $urandom_range(17);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_func <= f;
    in_ring <= r;
    in_column <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(known ? kres : tessellate(f, r, c));
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    start <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      cmg_pkg::CFG_SLICES: m_slices = val & 16'h07FF;
      cmg_pkg::CFG_RINGS:  m_rings  = val & 16'h07FF;
      cmg_pkg::CFG_RADIUS: m_radius = val;
      cmg_pkg::CFG_YOFF:   m_yoff   = val;
      cmg_pkg::CFG_HEIGHT: m_height = val;
      default: ;
    endcase
  endtask

  // Drain the pipe, then add an idle margin
  task automatic drain;
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic add_row(logic f, logic [9:0] r, logic [10:0] c, bit known,
                         mesh_out_t res);
    req_row_t row;
    row.func = f; row.ring = r; row.col = c; row.known = known; row.res = res;
    dir_rows.push_back(row);
  endtask

  initial begin
    mesh_out_t z, k, badres;
    logic [15:0] v_sl, v_rc, v_rad, v_yo, v_ht;
    int nitems;
    logic [9:0] rr;
    logic [10:0] cc;
    logic ff;

    rst_n = 1'b0; start = 1'b0; in_func = 1'b0; in_ring = '0; in_column = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    n_fail = 0; cycles = 0; no_idle = 0;
    m_slices = 16; m_rings = 2; m_radius = 256; m_yoff = 0; m_height = 256;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table at the reset configuration
    z = '{default: '0};
    badres = z; badres.bad = 1'b1;
    k = z; k.pos_x = 16'd256;
    add_row(0, 0, 0, 1, k);
    k = z; k.ca = 0; k.cb = 1; k.cc = 17; k.cd = 17; k.ce = 1; k.cf = 18;
    add_row(1, 0, 0, 1, k);
    k = z; k.pos_x = 16'd256; k.pos_y = 16'd256; k.tex_v = 15'd16384;
    add_row(0, 1, 0, 1, k);
    k = z; k.ca = 15; k.cb = 16; k.cc = 32; k.cd = 32; k.ce = 16; k.cf = 33;
    add_row(1, 0, 15, 1, k);
    add_row(0, 0, 4, 0, z);
    add_row(0, 0, 8, 0, z);
    add_row(0, 1, 12, 0, z);
    add_row(0, 1, 16, 0, z);     // seam column
    add_row(0, 0, 3, 0, z);
    add_row(1, 0, 7, 0, z);
    // out of range
    add_row(0, 2, 0, 1, badres);
    add_row(0, 0, 17, 1, badres);
    add_row(1, 1, 0, 1, badres);
    add_row(1, 0, 16, 1, badres);
    add_row(0, 10'h3FF, 11'h7FF, 1, badres);
    add_row(1, 10'h3FF, 11'h7FF, 1, badres);
    add_row(0, 10'h2AA, 11'h555, 1, badres);
    add_row(1, 10'h155, 11'h2AA, 1, badres);
    foreach (dir_rows[i])
      send_req(dir_rows[i].func, dir_rows[i].ring, dir_rows[i].col,
               dir_rows[i].known, dir_rows[i].res);
    drain();

    // Random phases, each under its own configuration
    for (int ph = 0; ph < 14; ph++) begin
      case (ph)
        0: begin v_sl = 1;    v_rc = 2;    v_rad = 16'hFFFF; v_yo = 16'h7FFF; v_ht = 16'hFFFF; end
        1: begin v_sl = 1024; v_rc = 1024; v_rad = 0;        v_yo = 16'h8000; v_ht = 0; end
        2: begin v_sl = 0;    v_rc = 2;    v_rad = 300;      v_yo = 16'h0100; v_ht = 512; end
        3: begin v_sl = 2047; v_rc = 1;    v_rad = 300;      v_yo = 0;        v_ht = 512; end
        4: begin v_sl = 16;   v_rc = 0;    v_rad = 300;      v_yo = 0;        v_ht = 512; end
        5: begin v_sl = 1024; v_rc = 1024; v_rad = 16'hFFFF; v_yo = 16'h7FFF; v_ht = 16'hFFFF; end
        6: begin v_sl = 1025; v_rc = 1025; v_rad = 16'hFFFF; v_yo = 16'h8000; v_ht = 16'hFFFF; end
        default: begin
          v_sl = 16'(($urandom_range(3) == 0) ? $urandom_range(1, 1024)
                                                : $urandom_range(1, 40));
          v_rc = 16'(($urandom_range(3) == 0) ? $urandom_range(2, 1024)
                                                : $urandom_range(2, 40));
          v_rad = 16'($urandom); v_yo = 16'($urandom); v_ht = 16'($urandom);
        end
      endcase
      write_reg(cmg_pkg::CFG_SLICES, v_sl);
      write_reg(cmg_pkg::CFG_RINGS, v_rc);
      write_reg(cmg_pkg::CFG_RADIUS, v_rad);
      write_reg(cmg_pkg::CFG_YOFF, v_yo);
      write_reg(cmg_pkg::CFG_HEIGHT, v_ht);
      // unused index: must change nothing
      write_reg(3'($urandom_range(5, 7)), 16'($urandom));
      no_idle = ($urandom_range(2) == 0);
      nitems = 135;
      for (int n = 0; n < nitems; n++) begin
        ff = 1'($urandom_range(1));
        if ($urandom_range(9) < 8 && m_slices > 0 && m_slices <= 1024 &&
            m_rings >= 2 && m_rings <= 1024) begin
          rr = 10'($urandom_range(0, int'(m_rings)));
          cc = 11'($urandom_range(0, int'(m_slices) + 1));
        end else begin
          rr = 10'($urandom);
          cc = 11'($urandom);
        end
        send_req(ff, rr, cc, 0, z);
        // in phase 8 only, hold the stream until the pipe empties once mid-phase
        if (n == nitems / 2 && ph == 8) begin
          start <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    if (pending_results.size() != 0) n_fail++;
    if (n_fail == 0) begin
      $display("cylinder_mesh_generator_tb passed");
    end else begin
      $display("cylinder_mesh_generator_tb failed");
    end
    $finish;
  end

endmodule
